### rtl/core/lbm_pkg.sv
// ----------------------------------------------------------------------------
// lbm_pkg
// Shared types, constants and colour helpers for the LED bar level meter.
// ----------------------------------------------------------------------------
package lbm_pkg;

    localparam int MAX_LEDS   = 64;
    localparam int BAR_LIM    = (MAX_LEDS < 64) ? MAX_LEDS : 64;
    localparam int CNT_W      = 7;
    localparam int IDX_W      = 6;
    localparam int LVL_W      = 16;
    localparam int MUL_B_W    = 8;
    localparam int PROD_W     = LVL_W + MUL_B_W;
    localparam int FULL_SCALE = 32768;
    localparam int RESET_LEDS = 8;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

    localparam t_rgb C_RED    = '{8'hff, 8'h00, 8'h00};
    localparam t_rgb C_YELLOW = '{8'hff, 8'h80, 8'h00};
    localparam t_rgb C_GREEN  = '{8'h00, 8'hfc, 8'h00};
    localparam t_rgb C_BLUE   = '{8'h00, 8'h00, 8'hff};
    localparam t_rgb C_BLACK  = '{8'h00, 8'h00, 8'h00};

    // base colour of one LED, and whether it is scaled by p / 2^15
    typedef struct packed {
        t_rgb              base;
        logic              scale;
        logic [LVL_W-1:0]  p;
    } t_led_cmd;

    function automatic logic [7:0] mix8(input logic [7:0] a, input logic [3:0] wa,
                                        input logic [7:0] b);
        logic [3:0]  wb;
        logic [11:0] s;
        wb = 4'd8 - wa;
        s  = ({4'd0, a} * {8'd0, wa}) + ({4'd0, b} * {8'd0, wb}) + 12'd4;
        return s[10:3];
    endfunction

    function automatic t_rgb blend8(input t_rgb a, input logic [3:0] wa, input t_rgb b);
        t_rgb o;
        o.r = mix8(a.r, wa, b.r);
        o.g = mix8(a.g, wa, b.g);
        o.b = mix8(a.b, wa, b.b);
        return o;
    endfunction

endpackage

### rtl/core/lbm_mul.sv
// ----------------------------------------------------------------------------
// lbm_mul
// Shared 16x8 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module lbm_mul
    import lbm_pkg::*;
(
    input  logic                i_clk,
    input  logic [LVL_W-1:0]    i_a,
    input  logic [MUL_B_W-1:0]  i_b,
    output logic [PROD_W-1:0]   o_prod
);

    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= {{MUL_B_W{1'b0}}, i_a} * {{LVL_W{1'b0}}, i_b};
    end

    assign o_prod = r_prod;

endmodule

### rtl/core/lbm_colour.sv
// ----------------------------------------------------------------------------
// lbm_colour
// Base color and scale request for one LED of the bar.
// ----------------------------------------------------------------------------
module lbm_colour
    import lbm_pkg::*;
(
    input  logic [IDX_W-1:0]  i_idx,
    input  logic [CNT_W-1:0]  i_n,
    input  logic [LVL_W-1:0]  i_level,
    input  logic [CNT_W-1:0]  i_high,
    input  logic [LVL_W-1:0]  i_pfrac,
    output t_led_cmd          o_cmd
);

    logic [9:0]       g8;
    logic [9:0]       y8;
    logic [9:0]       g8_up;
    logic [9:0]       y8_up;
    logic [CNT_W-1:0] lg;
    logic [CNT_W-1:0] hg;
    logic [CNT_W-1:0] ly;
    logic [CNT_W-1:0] hy;
    logic [CNT_W-1:0] idx7;
    logic [CNT_W:0]   nsum;
    logic [CNT_W-1:0] num;
    t_rgb             zone;

    assign g8    = ({3'd0, i_n} << 2) + {3'd0, i_n};
    assign y8    = ({3'd0, i_n} << 3) - {3'd0, i_n};
    assign g8_up = g8 + 10'd7;
    assign y8_up = y8 + 10'd7;
    assign lg    = g8[9:3];
    assign hg    = g8_up[9:3];
    assign ly    = y8[9:3];
    assign hy    = y8_up[9:3];
    assign idx7  = {1'b0, i_idx};
    assign nsum  = {1'b0, i_n} + 8'd7;
    assign num   = {2'd0, nsum[CNT_W:3]};

    always_comb begin
        if (idx7 < lg) begin
            zone = C_GREEN;
        end else if (idx7 >= hg && idx7 < ly) begin
            zone = C_YELLOW;
        end else if (idx7 >= hy) begin
            zone = C_RED;
        end else if (idx7 == lg && lg != hg) begin
            zone = blend8(C_GREEN, 4'd8 - {1'b0, g8[2:0]}, C_YELLOW);
        end else begin
            zone = blend8(C_YELLOW, 4'd8 - {1'b0, y8[2:0]}, C_RED);
        end
    end

    always_comb begin
        o_cmd.base  = C_BLACK;
        o_cmd.scale = 1'b0;
        o_cmd.p     = i_pfrac;
        if (i_n == 7'd1) begin
            o_cmd.base  = (i_level == '0) ? C_BLUE : C_GREEN;
            o_cmd.scale = (i_level != '0);
            o_cmd.p     = i_level;
        end else if (i_level == '0) begin
            // idle pattern, last blue LED dimmed by n mod 8
            o_cmd.p = {1'b0, i_n[2:0], 12'd0};
            if (idx7 < num) begin
                o_cmd.base  = C_BLUE;
                o_cmd.scale = (idx7 + 7'd1 == num) && (i_n[2:0] != 3'd0);
            end
        end else if (idx7 < i_high) begin
            o_cmd.base  = zone;
            o_cmd.scale = (idx7 + 7'd1 == i_high);
        end
    end

endmodule

### rtl/core/led_bar_level_meter.sv
// ----------------------------------------------------------------------------
// led_bar_level_meter
// Turns one Q15 peak level into one RGB color per LED of the bar.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_in_valid / o_in_stall carry i_level (Q15, 32768 = full
//   scale, larger values saturate). Output channel: o_out_valid / i_out_stall
//   carry one LED per transfer, led_index 0 first, o_last on the final LED.
//   i_cfg_we / i_cfg_data set the LED count (0 acts as 1, above 64 acts as 64).
//   One level yields N transfers. After states S_FILL and S_SETUP the LEDs
//   are loaded into the output register one by one; the one LED that is
//   scaled by its fractional fill first passes its three channels in turn
//   through the shared 16x8 multiplier (S_MR, S_MG, S_MB, S_PUT), which
//   also forms the fill N*level at setup.
//   The input is stalled while a level is being worked on and is taken again
//   once the last LED sits in the output register.
//   A stalled receiver holds the output register and the sequencer waits.
//   Reset empties the pipeline and sets the LED count to 8.
// ----------------------------------------------------------------------------
module led_bar_level_meter
    import lbm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CNT_W-1:0]   i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [LVL_W-1:0]   i_level,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [IDX_W-1:0]   o_led_index,
    output logic [7:0]         o_red,
    output logic [7:0]         o_green,
    output logic [7:0]         o_blue,
    output logic               o_last
);

    typedef enum logic [2:0] {
        S_IDLE, S_FILL, S_SETUP, S_LED, S_MR, S_MG, S_MB, S_PUT
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_led_count;
    logic [LVL_W-1:0]    r_level;
    logic [CNT_W-1:0]    r_n;
    logic [CNT_W-1:0]    r_high;
    logic [LVL_W-1:0]    r_pfrac;
    logic [IDX_W-1:0]    r_idx;
    t_rgb                r_base;
    logic [LVL_W-1:0]    r_p;
    logic [7:0]          r_sr;
    logic [7:0]          r_sg;
    logic                r_ovalid;
    logic [IDX_W-1:0]    r_oidx;
    t_rgb                r_orgb;
    logic                r_olast;

    logic [LVL_W-1:0]    lvl_sat;
    logic [CNT_W-1:0]    bar_n;
    logic [LVL_W-1:0]    mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [PROD_W-1:0]   prod;
    logic [PROD_W-1:0]   rsum;
    logic [7:0]          rnd;
    logic                frac_nz;
    t_led_cmd            cmd;
    logic                out_free;
    logic                ld;
    t_rgb                ld_rgb;
    logic                is_last;

    assign lvl_sat = (i_level > LVL_W'(FULL_SCALE)) ? LVL_W'(FULL_SCALE) : i_level;
    assign bar_n   = (r_led_count == '0) ? 7'd1 :
                     (r_led_count > CNT_W'(BAR_LIM)) ? CNT_W'(BAR_LIM) : r_led_count;

    always_comb begin
        mul_a = r_p;
        mul_b = r_base.b;
        unique case (r_state)
            S_FILL:  begin
                mul_a = r_level;
                mul_b = {1'b0, r_n};
            end
            S_MR:    mul_b = r_base.r;
            S_MG:    mul_b = r_base.g;
            default: ;
        endcase
    end

    lbm_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign rsum    = prod + PROD_W'(16384);
    assign rnd     = rsum[22:15];
    assign frac_nz = |prod[14:0];

    lbm_colour u_colour (
        .i_idx   (r_idx),
        .i_n     (r_n),
        .i_level (r_level),
        .i_high  (r_high),
        .i_pfrac (r_pfrac),
        .o_cmd   (cmd)
    );

    assign out_free = !r_ovalid || !i_out_stall;
    assign ld       = out_free && ((r_state == S_LED && !cmd.scale) || r_state == S_PUT);
    assign ld_rgb   = (r_state == S_PUT) ? {r_sr, r_sg, rnd} : cmd.base;
    assign is_last  = ({1'b0, r_idx} == r_n - 7'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ovalid    <= 1'b0;
            r_led_count <= CNT_W'(RESET_LEDS);
        end else begin
            if (i_cfg_we) begin
                r_led_count <= i_cfg_data;
            end
            if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_level <= lvl_sat;
                        r_n     <= bar_n;
                        r_state <= S_FILL;
                    end
                end
                S_FILL: r_state <= S_SETUP;
                S_SETUP: begin
                    r_high  <= prod[21:15] + {6'd0, frac_nz};
                    r_pfrac <= frac_nz ? {1'b0, prod[14:0]} : LVL_W'(FULL_SCALE);
                    r_idx   <= '0;
                    r_state <= S_LED;
                end
                S_LED: begin
                    if (cmd.scale) begin
                        r_base  <= cmd.base;
                        r_p     <= cmd.p;
                        r_state <= S_MR;
                    end
                end
                S_MR: r_state <= S_MG;
                S_MG: begin
                    r_sr    <= rnd;
                    r_state <= S_MB;
                end
                S_MB: begin
                    r_sg    <= rnd;
                    r_state <= S_PUT;
                end
                S_PUT: ;
                default: r_state <= S_IDLE;
            endcase
            if (ld) begin
                r_ovalid <= 1'b1;
                r_oidx   <= r_idx;
                r_orgb   <= ld_rgb;
                r_olast  <= is_last;
                if (is_last) begin
                    r_state <= S_IDLE;
                end else begin
                    r_idx   <= r_idx + 6'd1;
                    r_state <= S_LED;
                end
            end
        end
    end

    assign o_in_stall  = !i_rst_n || (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_led_index = r_oidx;
    assign o_red       = r_orgb.r;
    assign o_green     = r_orgb.g;
    assign o_blue      = r_orgb.b;
    assign o_last      = r_olast;

endmodule

### rtl/core/lbm_checker.sv
// ----------------------------------------------------------------------------
// lbm_checker
// Port-level checks for the LED bar level meter, bound to the top level.
// ----------------------------------------------------------------------------
module lbm_port_checks
    import lbm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               o_in_stall,
    input  logic               o_out_valid,
    input  logic               i_out_stall,
    input  logic [IDX_W-1:0]   o_led_index,
    input  logic [7:0]         o_red,
    input  logic [7:0]         o_green,
    input  logic [7:0]         o_blue,
    input  logic               o_last
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_led_index)
            && $stable(o_red) && $stable(o_green) && $stable(o_blue) && $stable(o_last))
        else $error("stalled output changed");

    // no new level while a bar is still in flight
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> o_in_stall)
        else $error("input taken mid-bar");

    // LEDs leave in order
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last |=>
            !o_out_valid || o_led_index == $past(o_led_index) + 6'd1)
        else $error("LED index out of order");

    // a bar starts at LED zero
    a_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> !o_out_valid || o_last || i_out_stall
            || o_led_index == '0)
        else $error("bar did not start at LED zero");

endmodule

bind led_bar_level_meter lbm_port_checks u_lbm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_led_index (o_led_index),
    .o_red       (o_red),
    .o_green     (o_green),
    .o_blue      (o_blue),
    .o_last      (o_last)
);

### verif/lbm_checker.sv
// ----------------------------------------------------------------------------
// lbm_checker
// Watches the config port and both channels of the LED bar level meter.
// Each level taken on the input builds the full expected bar, one entry per
// LED. Each LED transfer on the output is compared field by field against
// the oldest entry. Failures and outstanding entries go to the bench top.
// ----------------------------------------------------------------------------
module lbm_checker
    import lbm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CNT_W-1:0]   i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [LVL_W-1:0]   i_level,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [IDX_W-1:0]   i_led_index,
    input  logic [7:0]         i_red,
    input  logic [7:0]         i_green,
    input  logic [7:0]         i_blue,
    input  logic               i_last,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        t_rgb             rgb;
        logic             last;
    } t_led_exp;

    t_led_exp    expected_leds[$];
    int unsigned led_setting = RESET_LEDS;
    int          fail_total = 0;
    int          pending_count = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_count;

    // c * p / 2^15, rounded
    function automatic t_rgb scale_colour(input t_rgb c, input int unsigned p);
        t_rgb o;
        if (p >= FULL_SCALE) begin
            return c;
        end
        o.r = 8'((32'(c.r) * p + 32'd16384) >> 15);
        o.g = 8'((32'(c.g) * p + 32'd16384) >> 15);
        o.b = 8'((32'(c.b) * p + 32'd16384) >> 15);
        return o;
    endfunction

    // a weighted wa/8, b weighted (8-wa)/8, rounded
    function automatic t_rgb mix_colour(input t_rgb a, input int unsigned wa, input t_rgb b);
        t_rgb        o;
        int unsigned wb;
        wb  = 8 - wa;
        o.r = 8'((32'(a.r) * wa + 32'(b.r) * wb + 32'd4) >> 3);
        o.g = 8'((32'(a.g) * wa + 32'(b.g) * wb + 32'd4) >> 3);
        o.b = 8'((32'(a.b) * wa + 32'(b.b) * wb + 32'd4) >> 3);
        return o;
    endfunction

    function automatic t_rgb led_colour(input int unsigned n, input int unsigned lvl,
                                        input int unsigned i);
        t_rgb        c;
        int unsigned g8, y8, lg, hg, ly, hy, num, fill, high;
        c    = C_BLACK;
        g8   = 5 * n;
        y8   = 7 * n;
        lg   = g8 >> 3;
        hg   = (g8 + 7) >> 3;
        ly   = y8 >> 3;
        hy   = (y8 + 7) >> 3;
        num  = (n + 7) >> 3;
        fill = n * lvl;
        high = (fill + FULL_SCALE - 1) >> 15;
        if (n == 1) begin
            c = (lvl == 0) ? C_BLUE : scale_colour(C_GREEN, lvl);
        end else if (lvl == 0) begin
            if (i < num) begin
                c = C_BLUE;
                if (i == num - 1 && (n & 7) != 0) begin
                    c = scale_colour(C_BLUE, (n & 7) << 12);
                end
            end
        end else if (i < high) begin
            if (i < lg) begin
                c = C_GREEN;
            end else if (i >= hg && i < ly) begin
                c = C_YELLOW;
            end else if (i >= hy) begin
                c = C_RED;
            end else if (i == lg && lg != hg) begin
                c = mix_colour(C_GREEN, 8 - (g8 & 7), C_YELLOW);
            end else begin
                c = mix_colour(C_YELLOW, 8 - (y8 & 7), C_RED);
            end
            if (i == high - 1) begin
                c = scale_colour(c, fill - ((high - 1) << 15));
            end
        end
        return c;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_led_exp    got;
        t_led_exp    want;
        int unsigned n;
        int unsigned lvl;
        int unsigned i;
        if (!i_rst_n) begin
            led_setting = RESET_LEDS;
        end else begin
            if (i_cfg_we) begin
                led_setting = 32'(i_cfg_data);
            end
            if (i_out_valid && !i_out_stall) begin
                got.idx   = i_led_index;
                got.rgb.r = i_red;
                got.rgb.g = i_green;
                got.rgb.b = i_blue;
                got.last  = i_last;
                if (expected_leds.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10) begin
                        $display("Unexpected LED transfer: idx %0d rgb %06h last %0b",
                                 got.idx, got.rgb, got.last);
                    end
                end else begin
                    want = expected_leds.pop_front();
                    if (got.idx !== want.idx || got.rgb.r !== want.rgb.r ||
                        got.rgb.g !== want.rgb.g || got.rgb.b !== want.rgb.b ||
                        got.last !== want.last) begin
                        fail_total++;
                        if (fail_total <= 10) begin
                            $display("LED mismatch: exp %0d %06h %0b, got %0d %06h %0b",
                                     want.idx, want.rgb, want.last,
                                     got.idx, got.rgb, got.last);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                n   = (led_setting == 0) ? 1 : led_setting;
                n   = (n > BAR_LIM) ? BAR_LIM : n;
                lvl = (i_level > FULL_SCALE) ? FULL_SCALE : i_level;
                for (i = 0; i < n; i++) begin
                    want.idx = i[IDX_W-1:0];
                    want.rgb = led_colour(n, lvl, i);
                    want.last = (i == n - 1);
                    expected_leds.push_back(want);
                end
            end
        end
        pending_count = expected_leds.size();
    end

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Bench for the LED bar level meter. Drives directed and random levels over
// a range of LED counts. Both sides idle at random, but not in the last
// phase, and one long receiver hold-off fills the block. The checker
// predicts every LED; the top gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import lbm_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [CNT_W-1:0]   cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [LVL_W-1:0]   level;
    logic               out_valid;
    logic               out_stall;
    logic [IDX_W-1:0]   led_index;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic               led_last;

    int          fail_count;
    int          pending;
    int          tx_idle = 27;
    int          rx_idle = 52;
    int          hold_cycles = 0;
    int unsigned bar_leds = RESET_LEDS;

    led_bar_level_meter dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_level     (level),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_led_index (led_index),
        .o_red       (red),
        .o_green     (green),
        .o_blue      (blue),
        .o_last      (led_last)
    );

    lbm_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_level      (level),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_led_index  (led_index),
        .i_red        (red),
        .i_green      (green),
        .i_blue       (blue),
        .i_last       (led_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        #6000000;
        $display("Simulation FAILED");
        $finish;
    end

    // receiver: random stall, or a counted hold-off when requested
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_cycles > 0) begin
                out_stall <= 1'b1;
                hold_cycles--;
            end else begin
                out_stall <= ($urandom_range(99) < rx_idle);
            end
        end
    end

    task automatic send_level(input logic [LVL_W-1:0] v);
        while ($urandom_range(99) < tx_idle) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        level    <= v;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    // only written once the bar in flight has drained
    task automatic write_leds(input int unsigned v);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v[CNT_W-1:0];
        @(negedge clk);
        cfg_we   <= 1'b0;
        bar_leds = (v == 0) ? 1 : ((v > BAR_LIM) ? BAR_LIM : v);
    endtask

    initial begin
        int unsigned v;
        int unsigned k;
        rst_n    = 1'b0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        level    = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset count, zone edges, saturation, single LED, odd sizes
        send_level(16'd0);
        send_level(16'd32768);
        send_level(16'hffff);
        send_level(16'd16384);
        send_level(16'd20480);
        send_level(16'd28672);
        send_level(16'd1);
        write_leds(1);
        send_level(16'd0);
        send_level(16'd300);
        send_level(16'd32768);
        write_leds(0);
        send_level(16'd0);
        send_level(16'hffff);
        write_leds(127);
        send_level(16'd0);
        send_level(16'd32768);
        send_level(16'd32767);
        write_leds(13);
        send_level(16'd0);
        send_level(16'd21000);
        send_level(16'd28000);
        write_leds(2);
        send_level(16'd32768);
        send_level(16'd30000);
        send_level(16'd0);
        write_leds(64);
        send_level(16'd16383);

        for (int phase = 0; phase < 3; phase++) begin
            tx_idle = (phase == 0) ? 27 : ((phase == 1) ? 52 : 0);
            rx_idle = (phase == 0) ? 52 : ((phase == 1) ? 27 : 0);
            for (int seg = 0; seg < 7; seg++) begin
                case ($urandom_range(9))
                    0:       v = $urandom_range(127);
                    1:       v = 64;
                    2:       v = 0;
                    default: v = $urandom_range(1, 16);
                endcase
                write_leds(v);
                if (phase == 2 && seg == 0) begin
                    hold_cycles = 400;
                end
                for (int item = 0; item < 20; item++) begin
                    case ($urandom_range(9))
                        0: v = 0;
                        1: v = FULL_SCALE;
                        2: v = $urandom_range(65535);
                        3, 4: begin
                            k = $urandom_range(bar_leds);
                            v = k * FULL_SCALE / bar_leds + $urandom_range(2);
                            v = (v > 0) ? v - 1 : 0;
                        end
                        5: v = $urandom_range(255);
                        default: v = $urandom_range(FULL_SCALE);
                    endcase
                    send_level(v[LVL_W-1:0]);
                end
            end
        end

        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (80) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/lbm_pkg.sv
rtl/core/lbm_mul.sv
rtl/core/lbm_colour.sv
rtl/core/led_bar_level_meter.sv
rtl/core/lbm_checker.sv
verif/lbm_checker.sv
verif/tb_top.sv
